// ----- rtl/tte_pkg.sv -----
// ----------------------------------------------------------------------------
// tte_pkg: shared types and constants for the text terminal cell engine
// Field widths, character codes, operation codes and the row command beat.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int NumRowsDef = 8;
  localparam int NumColsDef = 30;

  localparam int FuncW      = 2;
  localparam int CharW      = 8;
  localparam int ReadRowW   = 3;
  localparam int ReadColW   = 5;
  localparam int CurRowOutW = 3;
  localparam int CurColOutW = 5;

  // Index widths that cover the whole parameter range (64 rows, 128 columns
  // plus the column past the last).
  localparam int MaxRowW = 6;
  localparam int MaxColW = 8;

  localparam logic [CharW-1:0] ChNl  = 8'h0A;
  localparam logic [CharW-1:0] ChCr  = 8'h0D;
  localparam logic [CharW-1:0] ChBs  = 8'h08;
  localparam logic [CharW-1:0] ChSp  = 8'h20;
  localparam logic [CharW-1:0] ChNul = 8'h00;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  // Work decided by the cursor for one item.
  typedef struct packed {
    logic               clear;
    logic               scroll;
    logic               pre_wr;
    logic               post_wr;
    logic [MaxRowW-1:0] pre_row;
    logic [MaxRowW-1:0] post_row;
    logic [MaxColW-1:0] wr_col;
    logic [CharW-1:0]   wr_data;
  } step_t;

  // Command seen by one row cell.
  typedef struct packed {
    logic               clear;
    logic               scroll;
    logic               pre_wr;
    logic               post_wr;
    logic [MaxColW-1:0] wr_col;
    logic [CharW-1:0]   wr_data;
  } row_cmd_t;

endpackage

// ----- rtl/tte_row_cell.sv -----
// ----------------------------------------------------------------------------
// tte_row_cell: one screen row of the cell chain
// Holds one row of byte cells, hands its zero-trimmed contents to the row
// above and takes the contents of the row below on a scroll, or spaces as the last row.
// ----------------------------------------------------------------------------
module tte_row_cell #(
  parameter int NUM_COLS = tte_pkg::NumColsDef,
  parameter bit LAST_ROW = 1'b0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tte_pkg::row_cmd_t                   cmd,
  input  logic [NUM_COLS*tte_pkg::CharW-1:0]  below_i,
  output logic [NUM_COLS*tte_pkg::CharW-1:0]  up_o,
  input  logic [tte_pkg::ReadColW-1:0]        rd_col,
  output logic [tte_pkg::CharW-1:0]           rd_byte
);

  logic [tte_pkg::CharW-1:0] cell_r   [NUM_COLS];
  logic [tte_pkg::CharW-1:0] cell_nxt [NUM_COLS];
  logic [tte_pkg::CharW-1:0] pre      [NUM_COLS];
  logic [tte_pkg::CharW-1:0] base     [NUM_COLS];
  logic                      ended;

  // newline zero lands before the row moves
  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      pre[c] = (cmd.pre_wr && cmd.wr_col == tte_pkg::MaxColW'(c)) ?
               tte_pkg::ChNul : cell_r[c];
    end
  end

  // trim from the first zero onward, hand upward
  always_comb begin
    ended = 1'b0;
    for (int c = 0; c < NUM_COLS; c++) begin
      if (pre[c] == tte_pkg::ChNul) ended = 1'b1;
      up_o[c*tte_pkg::CharW +: tte_pkg::CharW] = ended ? tte_pkg::ChNul : pre[c];
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      if (cmd.scroll) begin
        base[c] = LAST_ROW ? tte_pkg::ChSp : below_i[c*tte_pkg::CharW +: tte_pkg::CharW];
      end else begin
        base[c] = pre[c];
      end
      if (cmd.clear) begin
        cell_nxt[c] = tte_pkg::ChSp;
      end else if (cmd.post_wr && cmd.wr_col == tte_pkg::MaxColW'(c)) begin
        cell_nxt[c] = cmd.wr_data;
      end else begin
        cell_nxt[c] = base[c];
      end
    end
  end

  // out-of-range column reads as zero
  always_comb begin
    rd_byte = tte_pkg::ChNul;
    for (int c = 0; c < NUM_COLS; c++) begin
      if (tte_pkg::MaxColW'(rd_col) == tte_pkg::MaxColW'(c)) rd_byte = cell_r[c];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_COLS; c++) begin
      if (!rst_n) begin
        cell_r[c] <= tte_pkg::ChSp;
      end else begin
        cell_r[c] <= cell_nxt[c];
      end
    end
  end

endmodule

// ----- rtl/tte_cursor.sv -----
// ----------------------------------------------------------------------------
// tte_cursor: cursor register and per-item step decode
// Interprets one item against the cursor and issues the row writes, scroll
// and clear for the cell chain.
// ----------------------------------------------------------------------------
module tte_cursor #(
  parameter int NUM_ROWS = tte_pkg::NumRowsDef,
  parameter int NUM_COLS = tte_pkg::NumColsDef,
  localparam int RowW    = $clog2(NUM_ROWS),
  localparam int ColW    = $clog2(NUM_COLS + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [tte_pkg::FuncW-1:0]  func,
  input  logic [tte_pkg::CharW-1:0]  char_code,
  output tte_pkg::step_t             step,
  output logic [RowW-1:0]            row_nxt,
  output logic [ColW-1:0]            col_nxt
);

  localparam logic [RowW-1:0] LastRow = RowW'(NUM_ROWS - 1);
  localparam logic [ColW-1:0] ColEnd  = ColW'(NUM_COLS);

  logic [RowW-1:0] row_r;
  logic [ColW-1:0] col_r;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    step    = '0;
    if (accept) begin
      case (tte_pkg::func_t'(func))
        tte_pkg::FUNC_PUT: begin
          if (char_code == tte_pkg::ChNl) begin
            step.pre_wr  = (col_r != ColEnd);
            step.pre_row = tte_pkg::MaxRowW'(row_r);
            step.wr_col  = tte_pkg::MaxColW'(col_r);
            step.wr_data = tte_pkg::ChNul;
            col_nxt      = '0;
            if (row_r == LastRow) begin
              step.scroll = 1'b1;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end else if (char_code == tte_pkg::ChCr) begin
            col_nxt = '0;
          end else if (char_code == tte_pkg::ChBs) begin
            if (col_r != '0) col_nxt = col_r - 1'b1;
          end else if (char_code >= tte_pkg::ChSp) begin
            step.post_wr = 1'b1;
            step.wr_data = char_code;
            if (col_r == ColEnd) begin
              // wrap first, then write at column 0
              step.wr_col = '0;
              col_nxt     = ColW'(1);
              if (row_r == LastRow) begin
                step.scroll = 1'b1;
              end else begin
                row_nxt = row_r + 1'b1;
              end
            end else begin
              step.wr_col = tte_pkg::MaxColW'(col_r);
              col_nxt     = col_r + 1'b1;
            end
            step.post_row = tte_pkg::MaxRowW'(row_nxt);
          end
        end
        tte_pkg::FUNC_CLEAR: begin
          step.clear = 1'b1;
          row_nxt    = '0;
          col_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// ----- rtl/text_terminal_cell_engine_core.sv -----
// ----------------------------------------------------------------------------
// text_terminal_cell_engine_core: character-cell text terminal
// A screen of NUM_ROWS by NUM_COLS byte cells with a cursor, kept as a chain
// of row cells; put, read and clear operations, one result beat per item.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+----------------------
//   input    | in_func in_char_code in_read_row/col    | start && !busy
//   result   | out_cell_value out_cursor_*_out         | out_valid, 1 cycle
//            | out_did_scroll                          |
//
// One item per cycle: busy stays low and each accepted beat updates the
// cursor and every row cell at the same edge; its result beat shows on the
// next cycle. A scroll is one step of the row chain: every row cell loads the
// trimmed contents of the cell below it while the bottom cell loads spaces.
// Reset (synchronous, rst_n low) fills all cells with spaces and homes the
// cursor at once; there is no clearing pass. The receiver cannot stall, so
// each result is held for exactly one cycle.
// ----------------------------------------------------------------------------
module text_terminal_cell_engine_core #(
  parameter int NUM_ROWS = tte_pkg::NumRowsDef,
  parameter int NUM_COLS = tte_pkg::NumColsDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [tte_pkg::FuncW-1:0]       in_func,
  input  logic [tte_pkg::CharW-1:0]       in_char_code,
  input  logic [tte_pkg::ReadRowW-1:0]    in_read_row,
  input  logic [tte_pkg::ReadColW-1:0]    in_read_col,
  output logic                            out_valid,
  output logic [tte_pkg::CharW-1:0]       out_cell_value,
  output logic [tte_pkg::CurRowOutW-1:0]  out_cursor_row_out,
  output logic [tte_pkg::CurColOutW-1:0]  out_cursor_col_out,
  output logic                            out_did_scroll
);

  localparam int RowW  = $clog2(NUM_ROWS);
  localparam int ColW  = $clog2(NUM_COLS + 1);
  localparam int RowBW = NUM_COLS * tte_pkg::CharW;

  logic                      accept;
  tte_pkg::step_t            step;
  logic [RowW-1:0]           row_nxt;
  logic [ColW-1:0]           col_nxt;
  tte_pkg::row_cmd_t         cmd_w   [NUM_ROWS];
  logic [RowBW-1:0]          up_w    [NUM_ROWS];
  logic [RowBW-1:0]          below_w [NUM_ROWS];
  logic [tte_pkg::CharW-1:0] rd_w    [NUM_ROWS];
  logic [tte_pkg::CharW-1:0] rd_val;

  logic                           out_valid_r;
  logic [tte_pkg::CharW-1:0]      cell_value_r;
  logic [tte_pkg::CurRowOutW-1:0] cur_row_r;
  logic [tte_pkg::CurColOutW-1:0] cur_col_r;
  logic                           did_scroll_r;

  // every cycle takes a beat
  assign busy   = 1'b0;
  assign accept = start && !busy;

  tte_cursor #(
    .NUM_ROWS (NUM_ROWS),
    .NUM_COLS (NUM_COLS)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (in_func),
    .char_code (in_char_code),
    .step      (step),
    .row_nxt   (row_nxt),
    .col_nxt   (col_nxt)
  );

  // Fan the step out to the rows: the newline zero goes to the old cursor
  // row, the printable byte to the row the cursor ends on.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      cmd_w[r].clear   = step.clear;
      cmd_w[r].scroll  = step.scroll;
      cmd_w[r].pre_wr  = step.pre_wr  && (step.pre_row  == tte_pkg::MaxRowW'(r));
      cmd_w[r].post_wr = step.post_wr && (step.post_row == tte_pkg::MaxRowW'(r));
      cmd_w[r].wr_col  = step.wr_col;
      cmd_w[r].wr_data = step.wr_data;
    end
  end

  // Chain: each row sees the trimmed contents of the row below it.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (r == NUM_ROWS - 1) begin
        below_w[r] = '0;
      end else begin
        below_w[r] = up_w[r + 1];
      end
    end
  end

  for (genvar g = 0; g < NUM_ROWS; g++) begin : g_row
    tte_row_cell #(
      .NUM_COLS (NUM_COLS),
      .LAST_ROW (g == NUM_ROWS - 1)
    ) u_row (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd_w[g]),
      .below_i (below_w[g]),
      .up_o    (up_w[g]),
      .rd_col  (in_read_col),
      .rd_byte (rd_w[g])
    );
  end

  // Pick the addressed row; a row past the bottom reads as zero.
  always_comb begin
    rd_val = tte_pkg::ChNul;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (tte_pkg::MaxRowW'(in_read_row) == tte_pkg::MaxRowW'(r)) rd_val = rd_w[r];
    end
  end

  // Result beat: hold payload between beats, strobe for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cell_value_r <= (in_func == tte_pkg::FUNC_READ) ? rd_val : tte_pkg::ChNul;
      cur_row_r    <= tte_pkg::CurRowOutW'(row_nxt);
      cur_col_r    <= tte_pkg::CurColOutW'(col_nxt);
      did_scroll_r <= step.scroll;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cell_value     = cell_value_r;
  assign out_cursor_row_out = cur_row_r;
  assign out_cursor_col_out = cur_col_r;
  assign out_did_scroll     = did_scroll_r;

  // Every accepted beat yields a result beat on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat produced no result beat");

  // A scroll always leaves the cursor on the bottom row.
  a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_did_scroll) |->
      (out_cursor_row_out == tte_pkg::CurRowOutW'(NUM_ROWS - 1)))
    else $error("scroll reported with cursor off the bottom row");

  // Only a read returns a nonzero cell value.
  a_value_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cell_value != tte_pkg::ChNul) |->
      $past(in_func == tte_pkg::FUNC_READ))
    else $error("cell value on a non-read result");

  // Clear homes the cursor and never scrolls.
  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == tte_pkg::FUNC_CLEAR) |=>
      (out_cursor_row_out == '0 && out_cursor_col_out == '0 && !out_did_scroll))
    else $error("clear did not home the cursor");

endmodule
